[hw/rtl/dgt_pkg.sv]
// ============================================================================
// dgt_pkg - shared types and constants for the depth grid triangulator
// Sizes, register map, result record layout and beat sequencing codes.
// ============================================================================
package dgt_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int SIZE_W = 10;
    localparam int DIST_W = 16;
    localparam int IDX_W  = 18;
    localparam int Z_W    = 18;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [SIZE_W-1:0] MIN_SIZE        = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] MAX_WIDTH_SIZE  = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_HEIGHT_SIZE = SIZE_W'(MAX_HEIGHT);

    localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = SIZE_W'(512);
    localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = SIZE_W'(424);
    localparam logic [DIST_W-1:0] RST_NEAR_LIMIT   = DIST_W'(30);
    localparam logic [DIST_W-1:0] RST_FAR_LIMIT    = DIST_W'(400);

    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT,
        REG_NEAR_LIMIT,
        REG_FAR_LIMIT
    } reg_index_t;

    typedef enum logic [1:0] {
        BEAT_VERTEX,
        BEAT_TRI_FIRST,
        BEAT_TRI_SECOND
    } beat_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] index;
    } mark_t;

    typedef struct packed {
        logic                    has_tri;
        logic [COL_W-1:0]        pos_x;
        logic [ROW_W-1:0]        pos_y;
        logic signed [Z_W-1:0]   pos_z;
        logic [IDX_W-1:0]        tl;
        logic [IDX_W-1:0]        tr;
        logic [IDX_W-1:0]        bl;
        logic [IDX_W-1:0]        br;
        logic                    frame_end;
    } group_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] r;
        if (v < MIN_SIZE) begin
            r = MIN_SIZE;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[hw/rtl/depth_grid_triangulator.sv]
// An accepted pixel is registered in the pixel stage, then in the result stage.
// Throughput: one pixel per cycle while m_ready is high and pixels give at most
// one result; a pixel that closes a quad gives three result beats and holds the
// output until all are taken; the single result port gives one beat per cycle.
// Reset: synchronous active-low aresetn clears counters, marks and valid flags;
// the line buffer needs no clearing pass, each entry is written before it is used.
// ============================================================================
// depth_grid_triangulator - depth frame to indexed triangle mesh
// Raster-order depth pixels in, vertex and triangle records out. A line
// buffer keeps the previous row's vertex marks for quad detection.
// ============================================================================
module depth_grid_triangulator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dgt_pkg::ADDR_W-1:0]        paddr,
    input  logic [dgt_pkg::DATA_W-1:0]        pwdata,
    output logic [dgt_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [dgt_pkg::DIST_W-1:0]        s_distance,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_kind,
    output logic [dgt_pkg::COL_W-1:0]         m_pos_x,
    output logic [dgt_pkg::ROW_W-1:0]         m_pos_y,
    output logic signed [dgt_pkg::Z_W-1:0]    m_pos_z,
    output logic [dgt_pkg::IDX_W-1:0]         m_vertex_index,
    output logic [dgt_pkg::IDX_W-1:0]         m_corner_a,
    output logic [dgt_pkg::IDX_W-1:0]         m_corner_b,
    output logic [dgt_pkg::IDX_W-1:0]         m_corner_c,
    output logic                              m_last_of_pixel,
    output logic                              m_frame_end
);
    import dgt_pkg::*;

    // configuration
    logic [SIZE_W-1:0] frame_width_reg;
    logic [SIZE_W-1:0] frame_height_reg;
    logic [DIST_W-1:0] near_limit_reg;
    logic [DIST_W-1:0] far_limit_reg;
    logic              cfg_wr;
    reg_index_t        cfg_idx;

    // input side
    logic [COL_W-1:0]  col_count_reg;
    logic [ROW_W-1:0]  row_count_reg;
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;
    logic              in_last_col;
    logic              in_last_row;
    logic              accept;

    // line buffer
    mark_t             line_mem [MAX_WIDTH];
    mark_t             above_reg;

    // pixel stage
    logic              s1_valid_reg;
    logic [DIST_W-1:0] s1_dist_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic              s1_last_col_reg;
    logic              s1_last_row_reg;
    logic [IDX_W-1:0]  next_index_reg;
    mark_t             left_reg;
    mark_t             above_left_reg;
    logic              pix_ok;
    logic              quad_ok;
    logic              s1_adv;
    mark_t             cur;
    group_t            grp_next;

    // result stage
    logic              out_valid_reg;
    group_t            out_grp_reg;
    beat_t             beat_reg;
    logic              last_beat;
    logic              out_free;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_index_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            near_limit_reg   <= RST_NEAR_LIMIT;
            far_limit_reg    <= RST_FAR_LIMIT;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[SIZE_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[SIZE_W-1:0];
                REG_NEAR_LIMIT:   near_limit_reg   <= pwdata[DIST_W-1:0];
                REG_FAR_LIMIT:    far_limit_reg    <= pwdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_reg);
            REG_NEAR_LIMIT:   prdata = DATA_W'(near_limit_reg);
            REG_FAR_LIMIT:    prdata = DATA_W'(far_limit_reg);
            default:          prdata = '0;
        endcase
    end

    // input counters and line buffer read
    assign w_eff       = clamp_size(frame_width_reg, MAX_WIDTH_SIZE);
    assign h_eff       = clamp_size(frame_height_reg, MAX_HEIGHT_SIZE);
    assign in_last_col = (SIZE_W'(col_count_reg) + SIZE_W'(1)) >= w_eff;
    assign in_last_row = (SIZE_W'(row_count_reg) + SIZE_W'(1)) >= h_eff;
    assign accept      = s_valid & s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (accept) begin
            if (in_last_col) begin
                col_count_reg <= '0;
                row_count_reg <= in_last_row ? '0 : row_count_reg + ROW_W'(1);
            end else begin
                col_count_reg <= col_count_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            above_reg <= line_mem[col_count_reg];
        end
        if (s1_adv) begin
            line_mem[s1_col_reg] <= cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_dist_reg     <= s_distance;
            s1_col_reg      <= col_count_reg;
            s1_row_reg      <= row_count_reg;
            s1_last_col_reg <= in_last_col;
            s1_last_row_reg <= in_last_row;
        end
    end

    // pixel evaluation
    assign pix_ok    = (s1_dist_reg > near_limit_reg) && (s1_dist_reg < far_limit_reg);
    assign cur.valid = pix_ok;
    assign cur.index = pix_ok ? next_index_reg : '0;
    assign quad_ok   = (s1_row_reg != '0) && (s1_col_reg != '0) && pix_ok &&
                       above_reg.valid && left_reg.valid && above_left_reg.valid;
    assign out_free  = !out_valid_reg || (m_ready && last_beat);
    assign s1_adv    = s1_valid_reg && (!pix_ok || out_free);
    assign s_ready   = !s1_valid_reg || s1_adv;

    always_comb begin
        grp_next.has_tri   = quad_ok;
        grp_next.pos_x     = s1_col_reg;
        grp_next.pos_y     = s1_row_reg;
        grp_next.pos_z     = Z_W'(0) - Z_W'({s1_dist_reg, 1'b0});
        grp_next.tl        = above_left_reg.index;
        grp_next.tr        = above_reg.index;
        grp_next.bl        = left_reg.index;
        grp_next.br        = next_index_reg;
        grp_next.frame_end = s1_last_col_reg & s1_last_row_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            next_index_reg <= '0;
            left_reg       <= '0;
            above_left_reg <= '0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                if (s1_last_col_reg) begin
                    left_reg       <= '0;
                    above_left_reg <= '0;
                end else begin
                    left_reg       <= cur;
                    above_left_reg <= above_reg;
                end
                if (s1_last_col_reg && s1_last_row_reg) begin
                    next_index_reg <= '0;
                end else if (pix_ok) begin
                    next_index_reg <= next_index_reg + IDX_W'(1);
                end
            end
        end
    end

    // result beats
    assign last_beat = !out_grp_reg.has_tri || (beat_reg == BEAT_TRI_SECOND);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            beat_reg      <= BEAT_VERTEX;
        end else if (s1_adv && pix_ok) begin
            out_valid_reg <= 1'b1;
            beat_reg      <= BEAT_VERTEX;
        end else if (out_valid_reg && m_ready) begin
            if (last_beat) begin
                out_valid_reg <= 1'b0;
            end else begin
                case (beat_reg)
                    BEAT_VERTEX:    beat_reg <= BEAT_TRI_FIRST;
                    BEAT_TRI_FIRST: beat_reg <= BEAT_TRI_SECOND;
                    default:        beat_reg <= BEAT_VERTEX;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && pix_ok) begin
            out_grp_reg <= grp_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_frame_end = out_grp_reg.frame_end;

    always_comb begin
        m_kind          = KIND_TRIANGLE;
        m_pos_x         = '0;
        m_pos_y         = '0;
        m_pos_z         = '0;
        m_vertex_index  = '0;
        m_corner_a      = '0;
        m_corner_b      = '0;
        m_corner_c      = '0;
        m_last_of_pixel = 1'b0;
        case (beat_reg)
            BEAT_VERTEX: begin
                m_kind          = KIND_VERTEX;
                m_pos_x         = out_grp_reg.pos_x;
                m_pos_y         = out_grp_reg.pos_y;
                m_pos_z         = out_grp_reg.pos_z;
                m_vertex_index  = out_grp_reg.br;
                m_last_of_pixel = !out_grp_reg.has_tri;
            end
            BEAT_TRI_FIRST: begin
                m_corner_a = out_grp_reg.tl;
                m_corner_b = out_grp_reg.tr;
                m_corner_c = out_grp_reg.br;
            end
            BEAT_TRI_SECOND: begin
                m_corner_a      = out_grp_reg.tl;
                m_corner_b      = out_grp_reg.br;
                m_corner_c      = out_grp_reg.bl;
                m_last_of_pixel = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

[dv/dgt_mesh_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// dgt_mesh_checker - scoreboard for the depth grid triangulator
// Snoops APB writes and the pixel channel, predicts the vertex and triangle
// beats each accepted pixel gives, and compares every result beat in order.
// ============================================================================
module dgt_mesh_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dgt_pkg::ADDR_W-1:0]        paddr,
    input  logic [dgt_pkg::DATA_W-1:0]        pwdata,
    input  logic                              pready,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [dgt_pkg::DIST_W-1:0]        s_distance,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic                              m_kind,
    input  logic [dgt_pkg::COL_W-1:0]         m_pos_x,
    input  logic [dgt_pkg::ROW_W-1:0]         m_pos_y,
    input  logic signed [dgt_pkg::Z_W-1:0]    m_pos_z,
    input  logic [dgt_pkg::IDX_W-1:0]         m_vertex_index,
    input  logic [dgt_pkg::IDX_W-1:0]         m_corner_a,
    input  logic [dgt_pkg::IDX_W-1:0]         m_corner_b,
    input  logic [dgt_pkg::IDX_W-1:0]         m_corner_c,
    input  logic                              m_last_of_pixel,
    input  logic                              m_frame_end,
    output int                                error_count,
    output int                                pending
);
    import dgt_pkg::*;

    typedef struct {
        logic                  kind;
        logic [COL_W-1:0]      pos_x;
        logic [ROW_W-1:0]      pos_y;
        logic signed [Z_W-1:0] pos_z;
        logic [IDX_W-1:0]      vertex_index;
        logic [IDX_W-1:0]      corner_a;
        logic [IDX_W-1:0]      corner_b;
        logic [IDX_W-1:0]      corner_c;
        logic                  last_of_pixel;
        logic                  frame_end;
    } mesh_beat_t;

    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [DIST_W-1:0] near_reg;
    logic [DIST_W-1:0] far_reg;

    int               col_cnt;
    int               row_cnt;
    logic [IDX_W-1:0] next_vertex;
    mark_t            above_marks [MAX_WIDTH];
    mark_t            left_mark;
    mark_t            diag_mark;
    mesh_beat_t       expected_beats [$];

    function automatic int clamp_dim(input int v, input int hi);
        if (v < 2) begin
            return 2;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic mesh_beat_t triangle_beat(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b,
                                                 input logic [IDX_W-1:0] c,
                                                 input logic lop, input logic fe);
        mesh_beat_t t;
        t.kind          = KIND_TRIANGLE;
        t.pos_x         = '0;
        t.pos_y         = '0;
        t.pos_z         = '0;
        t.vertex_index  = '0;
        t.corner_a      = a;
        t.corner_b      = b;
        t.corner_c      = c;
        t.last_of_pixel = lop;
        t.frame_end     = fe;
        return t;
    endfunction

    task automatic predict_pixel(input logic [DIST_W-1:0] depth);
        mesh_beat_t vtx;
        mark_t      above;
        mark_t      cur;
        logic       last_col;
        logic       last_row;
        logic       fe;
        logic       quad;
        last_col = (col_cnt + 1 >= clamp_dim(int'(width_reg), MAX_WIDTH));
        last_row = (row_cnt + 1 >= clamp_dim(int'(height_reg), MAX_HEIGHT));
        fe       = last_col && last_row;
        above    = above_marks[col_cnt];
        cur      = '0;
        cur.valid = (depth > near_reg) && (depth < far_reg);
        cur.index = cur.valid ? next_vertex : '0;
        quad = (row_cnt > 0) && (col_cnt > 0) && cur.valid && above.valid &&
               left_mark.valid && diag_mark.valid;

        if (cur.valid) begin
            vtx.kind          = KIND_VERTEX;
            vtx.pos_x         = COL_W'(col_cnt);
            vtx.pos_y         = ROW_W'(row_cnt);
            vtx.pos_z         = Z_W'(-2 * int'(depth));
            vtx.vertex_index  = next_vertex;
            vtx.corner_a      = '0;
            vtx.corner_b      = '0;
            vtx.corner_c      = '0;
            vtx.last_of_pixel = !quad;
            vtx.frame_end     = fe;
            expected_beats = {expected_beats, vtx};
            next_vertex = next_vertex + IDX_W'(1);
        end
        if (quad) begin
            expected_beats = {expected_beats,
                              triangle_beat(diag_mark.index, above.index,
                                            cur.index, 1'b0, fe)};
            expected_beats = {expected_beats,
                              triangle_beat(diag_mark.index, cur.index,
                                            left_mark.index, 1'b1, fe)};
        end

        diag_mark            = above;
        above_marks[col_cnt] = cur;
        left_mark            = cur;
        if (last_col) begin
            col_cnt   = 0;
            left_mark = '0;
            diag_mark = '0;
            if (last_row) begin
                row_cnt     = 0;
                next_vertex = '0;
            end else begin
                row_cnt++;
            end
        end else begin
            col_cnt++;
        end
    endtask

    task automatic check_field(input string name, input logic signed [31:0] expv,
                               input logic signed [31:0] actv);
        if (actv !== expv) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
            error_count++;
        end
    endtask

    task automatic check_beat();
        mesh_beat_t exp_beat;
        if (expected_beats.size() == 0) begin
            $error("result beat with nothing expected (kind %0d)", m_kind);
            error_count++;
        end else begin
            exp_beat = expected_beats.pop_front();
            check_field("kind", exp_beat.kind, m_kind);
            check_field("pos_x", exp_beat.pos_x, m_pos_x);
            check_field("pos_y", exp_beat.pos_y, m_pos_y);
            check_field("pos_z", exp_beat.pos_z, m_pos_z);
            check_field("vertex_index", exp_beat.vertex_index, m_vertex_index);
            check_field("corner_a", exp_beat.corner_a, m_corner_a);
            check_field("corner_b", exp_beat.corner_b, m_corner_b);
            check_field("corner_c", exp_beat.corner_c, m_corner_c);
            check_field("last_of_pixel", exp_beat.last_of_pixel, m_last_of_pixel);
            check_field("frame_end", exp_beat.frame_end, m_frame_end);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   = RST_FRAME_WIDTH;
            height_reg  = RST_FRAME_HEIGHT;
            near_reg    = RST_NEAR_LIMIT;
            far_reg     = RST_FAR_LIMIT;
            col_cnt     = 0;
            row_cnt     = 0;
            next_vertex = '0;
            left_mark   = '0;
            diag_mark   = '0;
            foreach (above_marks[i]) begin
                above_marks[i] = '0;
            end
            expected_beats.delete();
            error_count = 0;
            pending     = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_index_t'(paddr[ADDR_W-1:2]))
                    REG_FRAME_WIDTH:  width_reg  = pwdata[SIZE_W-1:0];
                    REG_FRAME_HEIGHT: height_reg = pwdata[SIZE_W-1:0];
                    REG_NEAR_LIMIT:   near_reg   = pwdata[DIST_W-1:0];
                    REG_FAR_LIMIT:    far_reg    = pwdata[DIST_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predict_pixel(s_distance);
            end
            if (m_valid && m_ready) begin
                check_beat();
            end
            pending = expected_beats.size();
        end
    end

endmodule

[dv/depth_grid_triangulator_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// depth_grid_triangulator_tb - testbench top for the depth grid triangulator
// Drives pixel beats with random idle gaps and APB writes, stalls results at
// random; the checker predicts and compares every result beat.
// ============================================================================
module depth_grid_triangulator_tb;
    import dgt_pkg::*;

    localparam int RUN_LIMIT     = 300000;
    localparam int RANDOM_PIXELS = 400;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    logic [DIST_W-1:0]     s_distance;
    logic                  m_valid;
    logic                  m_ready = 1'b1;
    logic                  m_kind;
    logic [COL_W-1:0]      m_pos_x;
    logic [ROW_W-1:0]      m_pos_y;
    logic signed [Z_W-1:0] m_pos_z;
    logic [IDX_W-1:0]      m_vertex_index;
    logic [IDX_W-1:0]      m_corner_a;
    logic [IDX_W-1:0]      m_corner_b;
    logic [IDX_W-1:0]      m_corner_c;
    logic                  m_last_of_pixel;
    logic                  m_frame_end;

    int error_count;
    int pending;
    int cycle_count  = 0;
    int stall_left   = 0;
    int pixels_sent  = 0;
    bit idle_on      = 1'b1;

    // stimulus-side view of the frame position, for finishing frames
    int tb_w     = 512;
    int tb_h     = 424;
    int near_val = 30;
    int far_val  = 400;
    int col_pos  = 0;
    int row_pos  = 0;

    always #5 aclk = ~aclk;

    depth_grid_triangulator u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_distance      (s_distance),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_pos_x         (m_pos_x),
        .m_pos_y         (m_pos_y),
        .m_pos_z         (m_pos_z),
        .m_vertex_index  (m_vertex_index),
        .m_corner_a      (m_corner_a),
        .m_corner_b      (m_corner_b),
        .m_corner_c      (m_corner_c),
        .m_last_of_pixel (m_last_of_pixel),
        .m_frame_end     (m_frame_end)
    );

    dgt_mesh_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_distance      (s_distance),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_pos_x         (m_pos_x),
        .m_pos_y         (m_pos_y),
        .m_pos_z         (m_pos_z),
        .m_vertex_index  (m_vertex_index),
        .m_corner_a      (m_corner_a),
        .m_corner_b      (m_corner_b),
        .m_corner_c      (m_corner_c),
        .m_last_of_pixel (m_last_of_pixel),
        .m_frame_end     (m_frame_end),
        .error_count     (error_count),
        .pending         (pending)
    );

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result-side backpressure in bursts of random length
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_on && aresetn && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic int clamp_dim(input int v, input int hi);
        if (v < 2) begin
            return 2;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [DIST_W-1:0] pick_distance();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 15 && far_val > near_val + 1) begin
            return DIST_W'($urandom_range(near_val + 1, far_val - 1));
        end else if (sel == 15) begin
            return DIST_W'(near_val);
        end else if (sel == 16) begin
            return DIST_W'(far_val);
        end
        return DIST_W'($urandom_range(0, 65535));
    endfunction

    task automatic write_reg(input reg_index_t idx, input int value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  tb_w     = clamp_dim(value & 'h3FF, MAX_WIDTH);
            REG_FRAME_HEIGHT: tb_h     = clamp_dim(value & 'h3FF, MAX_HEIGHT);
            REG_NEAR_LIMIT:   near_val = value & 'hFFFF;
            REG_FAR_LIMIT:    far_val  = value & 'hFFFF;
            default: ;
        endcase
    endtask

    task automatic set_frame(input int w, input int h, input int near_lim, input int far_lim);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_NEAR_LIMIT, near_lim);
        write_reg(REG_FAR_LIMIT, far_lim);
    endtask

    task automatic push_pixel(input logic [DIST_W-1:0] depth);
        int gap;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_distance <= depth;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pixels_sent++;
        if (col_pos + 1 >= tb_w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= tb_h) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    task automatic finish_frame();
        push_pixel(pick_distance());
        while (col_pos != 0 || row_pos != 0) push_pixel(pick_distance());
    endtask

    // config writes only once all results are out and the pipe has emptied
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    initial begin
        logic [DIST_W-1:0] quad_px  [8]  = '{16'd1, 16'd65534, 16'd32768, 16'h5555,
                                             16'd0, 16'd65535, 16'hAAAA, 16'd5};
        logic [DIST_W-1:0] dead_px  [4]  = '{16'd31, 16'd200, 16'd65535, 16'd0};
        logic [DIST_W-1:0] limit_px [12] = '{16'd31, 16'd399, 16'd30,
                                             16'd100, 16'd398, 16'd400,
                                             16'd200, 16'd201, 16'd202,
                                             16'd50, 16'd60, 16'd70};
        int random_base;
        int w;
        int h;
        int near_lim;
        int far_lim;
        int part;

        aresetn    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_valid    = 1'b0;
        s_distance = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // 2x2 frames from under-range sizes, widest limits, field extremes
        set_frame(1, 0, 0, 65535);
        foreach (quad_px[i]) push_pixel(quad_px[i]);
        wait_idle();

        // near above far: nothing valid
        set_frame(2, 2, 65535, 0);
        foreach (dead_px[i]) push_pixel(dead_px[i]);
        wait_idle();

        // limit boundaries, tallest frame, then height shrunk mid-frame
        set_frame(3, 1023, 30, 400);
        for (int i = 0; i < 9; i++) push_pixel(limit_px[i]);
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, 2);
        for (int i = 9; i < 12; i++) push_pixel(limit_px[i]);
        wait_idle();

        // widest frame, then width shrunk below the current column
        set_frame(1023, 2, 30, 400);
        repeat (20) push_pixel(pick_distance());
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 4);
        finish_frame();

        random_base = pixels_sent;
        while (pixels_sent - random_base < RANDOM_PIXELS) begin
            if (pixels_sent - random_base > RANDOM_PIXELS * 4 / 5) begin
                idle_on = 1'b0;
            end
            wait_idle();
            w = $urandom_range(0, 9);
            h = $urandom_range(0, 6);
            case ($urandom_range(0, 7))
                0: begin
                    near_lim = $urandom_range(0, 65535);
                    far_lim  = $urandom_range(0, near_lim);
                end
                1: begin
                    near_lim = 0;
                    far_lim  = 65535;
                end
                default: begin
                    near_lim = $urandom_range(0, 2000);
                    far_lim  = near_lim + $urandom_range(2, 3000);
                end
            endcase
            set_frame(w, h, near_lim, far_lim);
            if ($urandom_range(0, 4) == 0) begin
                part = $urandom_range(1, tb_w * tb_h - 1);
                repeat (part) push_pixel(pick_distance());
                wait_idle();
                // width may only shrink mid-frame, height may go either way
                write_reg(REG_FRAME_WIDTH, $urandom_range(2, tb_w));
                write_reg(REG_FRAME_HEIGHT, $urandom_range(0, 8));
                if (col_pos != 0 || row_pos != 0) begin
                    finish_frame();
                end
            end else begin
                finish_frame();
            end
        end

        wait_idle();
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
